FILE: src/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Payload structs, token kinds, the queue descriptor and the keyword table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int LINE_BITS   = 32;
  localparam int NUMBER_BITS = 63;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [NUMBER_BITS-1:0] NUM_MAX  = '1;

  // ASCII codes the classifier cares about
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_SEVEN      = 8'h37;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_F    = 8'h66;
  localparam logic [7:0] CH_LOWER_T    = 8'h74;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  typedef enum logic [4:0] {
    KIND_UNKNOWN   = 5'd0,
    KIND_LINE      = 5'd1,
    KIND_STR_CHAR  = 5'd2,
    KIND_STR_END   = 5'd3,
    KIND_NAME_CHAR = 5'd4,
    KIND_NAME_END  = 5'd5,
    KIND_KW_FUNC   = 5'd6,
    KIND_KW_RETURN = 5'd7,
    KIND_NUMBER    = 5'd8,
    KIND_LPAREN    = 5'd9,
    KIND_RPAREN    = 5'd10,
    KIND_LBRACE    = 5'd11,
    KIND_RBRACE    = 5'd12,
    KIND_SPACE     = 5'd13,
    KIND_SEMI      = 5'd14,
    KIND_EQUAL     = 5'd15,
    KIND_PLUS      = 5'd16,
    KIND_MINUS     = 5'd17,
    KIND_STAR      = 5'd18,
    KIND_SLASH     = 5'd19
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [7:0]  char_value;
    logic [62:0] number_value;
    logic [31:0] line_number;
    logic        run_last;
    logic        stream_end;
  } token_t;

  // One optional single token inside a descriptor
  typedef struct packed {
    logic       valid;
    logic [4:0] kind;
    logic [7:0] ch;
  } slot_t;

  // Everything one byte produces, in emission order:
  // line-1 mark, held prefix, t1, t2, held prefix at close, t3
  typedef struct packed {
    logic                   first_mark;
    logic                   f1_sel;
    logic [3:0]             f1_cnt;
    slot_t                  t1;
    slot_t                  t2;
    logic                   f2_sel;
    logic [3:0]             f2_cnt;
    slot_t                  t3;
    logic [NUMBER_BITS-1:0] number;
    logic [31:0]            line;
    logic                   last;
  } desc_t;

  function automatic slot_t make_slot(input kind_t kind, input logic [7:0] ch);
    slot_t s;
    s.valid = 1'b1;
    s.kind  = kind;
    s.ch    = ch;
    return s;
  endfunction

  // sel 0: "functie", sel 1: "teruggave"
  function automatic logic [3:0] kw_len(input logic sel);
    return sel ? 4'd9 : 4'd7;
  endfunction

  function automatic logic [7:0] kw_char(input logic sel, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (!sel) begin
      case (pos)
        4'd0: ch = "f";
        4'd1: ch = "u";
        4'd2: ch = "n";
        4'd3: ch = "c";
        4'd4: ch = "t";
        4'd5: ch = "i";
        4'd6: ch = "e";
        default: ch = 8'h00;
      endcase
    end else begin
      case (pos)
        4'd0: ch = "t";
        4'd1: ch = "e";
        4'd2: ch = "r";
        4'd3: ch = "u";
        4'd4: ch = "g";
        4'd5: ch = "g";
        4'd6: ch = "a";
        4'd7: ch = "v";
        4'd8: ch = "e";
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c inside {[8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_MINUS || c == CH_UNDERSCORE;
  endfunction

endpackage

FILE: src/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front: byte classifier and scan state
// Takes one byte per transfer, updates the scan state and builds the
// descriptor of the tokens that byte causes.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  item_t item,
  output desc_t desc,
  output logic  has_tokens
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_NAME   = 2'd2,
    MODE_NUMBER = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CAND_NONE = 2'd0,
    CAND_FUNC = 2'd1,
    CAND_RET  = 2'd2
  } cand_t;

  mode_t                  mode, mode_next;
  cand_t                  cand, cand_next;
  logic [3:0]             held, held_next;
  logic [LINE_BITS-1:0]   line_count, line_next;
  logic [NUMBER_BITS-1:0] acc, acc_next;
  logic                   octal, octal_next;
  logic                   stopped, stopped_next;

  logic [7:0]             c;
  logic                   do_dispatch;
  logic                   sel_now;
  logic                   sel_close;
  logic [NUMBER_BITS+3:0] acc_wide;
  logic [NUMBER_BITS+3:0] acc_times2;
  logic [NUMBER_BITS+3:0] acc_prod;
  logic [NUMBER_BITS-1:0] acc_sat;
  logic [LINE_BITS+31:0]  line_wide;

  assign c = item.byte_value;

  // acc * base + digit, saturating
  assign acc_wide   = {4'b0, acc};
  assign acc_times2 = octal ? '0 : (acc_wide << 1);
  assign acc_prod   = (acc_wide << 3) + acc_times2 + (NUMBER_BITS + 4)'(c[3:0]);
  assign acc_sat    = (acc_prod > {4'b0, NUM_MAX}) ? NUM_MAX : acc_prod[NUMBER_BITS-1:0];

  assign sel_now = (cand == CAND_RET);

  always_comb begin
    mode_next    = mode;
    cand_next    = cand;
    held_next    = held;
    line_next    = line_count;
    acc_next     = acc;
    octal_next   = octal;
    stopped_next = stopped;
    do_dispatch  = 1'b0;
    sel_close    = 1'b0;
    line_wide    = '0;
    desc         = '0;
    desc.first_mark = item.first_byte;
    desc.last       = item.last_byte;

    if (item.first_byte) begin
      mode_next    = MODE_IDLE;
      cand_next    = CAND_NONE;
      held_next    = '0;
      line_next    = LINE_BITS'(1);
      acc_next     = '0;
      octal_next   = 1'b0;
      stopped_next = 1'b0;
    end

    case (mode_next)
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          desc.t1   = make_slot(KIND_STR_END, 8'h00);
          mode_next = MODE_IDLE;
        end else begin
          desc.t1 = make_slot(KIND_STR_CHAR, c);
        end
      end
      MODE_NAME: begin
        if (is_name_char(c)) begin
          if (cand != CAND_NONE && held < kw_len(sel_now) && c == kw_char(sel_now, held)) begin
            held_next = held + 4'd1;
          end else begin
            if (cand != CAND_NONE) begin
              desc.f1_sel = sel_now;
              desc.f1_cnt = held;
            end
            cand_next = CAND_NONE;
            held_next = '0;
            desc.t1   = make_slot(KIND_NAME_CHAR, c);
          end
        end else begin
          if (cand != CAND_NONE && held == kw_len(sel_now)) begin
            desc.t1 = make_slot(sel_now ? KIND_KW_RETURN : KIND_KW_FUNC, 8'h00);
          end else begin
            if (cand != CAND_NONE) begin
              desc.f1_sel = sel_now;
              desc.f1_cnt = held;
            end
            desc.t1 = make_slot(KIND_NAME_END, 8'h00);
          end
          cand_next   = CAND_NONE;
          held_next   = '0;
          mode_next   = MODE_IDLE;
          do_dispatch = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_hex(c)) begin
          if (!stopped) begin
            if (!is_digit(c) || (octal && c > CH_SEVEN)) begin
              stopped_next = 1'b1;
            end else begin
              acc_next = acc_sat;
            end
          end
        end else begin
          desc.t1      = make_slot(KIND_NUMBER, 8'h00);
          desc.number  = acc;
          acc_next     = '0;
          octal_next   = 1'b0;
          stopped_next = 1'b0;
          mode_next    = MODE_IDLE;
          do_dispatch  = 1'b1;
        end
      end
      default: begin
        do_dispatch = 1'b1;
      end
    endcase

    if (do_dispatch) begin
      case (c)
        CH_QUOTE:    mode_next = MODE_STRING;
        CH_LPAREN:   desc.t2 = make_slot(KIND_LPAREN, 8'h00);
        CH_RPAREN:   desc.t2 = make_slot(KIND_RPAREN, 8'h00);
        CH_LBRACE:   desc.t2 = make_slot(KIND_LBRACE, 8'h00);
        CH_RBRACE:   desc.t2 = make_slot(KIND_RBRACE, 8'h00);
        CH_SPACE:    desc.t2 = make_slot(KIND_SPACE, 8'h00);
        CH_SEMI:     desc.t2 = make_slot(KIND_SEMI, 8'h00);
        CH_EQUAL:    desc.t2 = make_slot(KIND_EQUAL, 8'h00);
        CH_PLUS:     desc.t2 = make_slot(KIND_PLUS, 8'h00);
        CH_MINUS:    desc.t2 = make_slot(KIND_MINUS, 8'h00);
        CH_STAR:     desc.t2 = make_slot(KIND_STAR, 8'h00);
        CH_SLASH:    desc.t2 = make_slot(KIND_SLASH, 8'h00);
        CH_NEWLINE: begin
          if (line_next != LINE_MAX) begin
            line_next = line_next + LINE_BITS'(1);
          end
          line_wide = {32'b0, line_next};
          desc.line = line_wide[31:0];
          desc.t2   = make_slot(KIND_LINE, 8'h00);
        end
        default: begin
          if (is_alpha(c)) begin
            mode_next = MODE_NAME;
            // a keyword's first letter always matches, so hold it
            if (c == CH_LOWER_F) begin
              cand_next = CAND_FUNC;
              held_next = 4'd1;
            end else if (c == CH_LOWER_T) begin
              cand_next = CAND_RET;
              held_next = 4'd1;
            end else begin
              cand_next = CAND_NONE;
              held_next = '0;
              desc.t2   = make_slot(KIND_NAME_CHAR, c);
            end
          end else if (is_digit(c)) begin
            mode_next    = MODE_NUMBER;
            octal_next   = (c == CH_ZERO);
            acc_next     = NUMBER_BITS'(c[3:0]);
            stopped_next = 1'b0;
          end else begin
            desc.t2 = make_slot(KIND_UNKNOWN, 8'h00);
          end
        end
      endcase
    end

    // close whatever is still open at the end of the buffer
    if (item.last_byte) begin
      case (mode_next)
        MODE_STRING: begin
          desc.t3   = make_slot(KIND_STR_END, 8'h00);
          mode_next = MODE_IDLE;
        end
        MODE_NAME: begin
          sel_close = (cand_next == CAND_RET);
          if (cand_next != CAND_NONE && held_next == kw_len(sel_close)) begin
            desc.t3 = make_slot(sel_close ? KIND_KW_RETURN : KIND_KW_FUNC, 8'h00);
          end else begin
            if (cand_next != CAND_NONE) begin
              desc.f2_sel = sel_close;
              desc.f2_cnt = held_next;
            end
            desc.t3 = make_slot(KIND_NAME_END, 8'h00);
          end
          cand_next = CAND_NONE;
          held_next = '0;
          mode_next = MODE_IDLE;
        end
        MODE_NUMBER: begin
          desc.t3      = make_slot(KIND_NUMBER, 8'h00);
          desc.number  = acc_next;
          acc_next     = '0;
          octal_next   = 1'b0;
          stopped_next = 1'b0;
          mode_next    = MODE_IDLE;
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end
  end

  assign has_tokens = desc.first_mark || desc.f1_cnt != 4'd0 || desc.t1.valid
                   || desc.t2.valid || desc.f2_cnt != 4'd0 || desc.t3.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      cand       <= CAND_NONE;
      held       <= '0;
      line_count <= LINE_BITS'(1);
      acc        <= '0;
      octal      <= 1'b0;
      stopped    <= 1'b0;
    end else if (take) begin
      mode       <= mode_next;
      cand       <= cand_next;
      held       <= held_next;
      line_count <= line_next;
      acc        <= acc_next;
      octal      <= octal_next;
      stopped    <= stopped_next;
    end
  end

endmodule

FILE: src/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue: descriptor queue
// Short first-in first-out buffer between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  desc_t wr_data,
  input  logic  rd_en,
  output desc_t rd_data,
  output logic  full,
  output logic  empty
);

  desc_t                entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign rd_data = entries[rd_ptr];
  assign full    = (count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        entries[wr_ptr] <= wr_data;
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back: token sequencer
// Walks the head descriptor one token per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  desc_t  head,
  input  logic   head_empty,
  output logic   head_pop,
  input  logic   pop,
  output logic   empty,
  output token_t token
);

  localparam int PHASES = 6;

  typedef enum logic [2:0] {
    PH_LINE1  = 3'd0,
    PH_FLUSH1 = 3'd1,
    PH_TOK1   = 3'd2,
    PH_TOK2   = 3'd3,
    PH_FLUSH2 = 3'd4,
    PH_TOK3   = 3'd5
  } phase_t;

  phase_t            phase;
  phase_t            cur;
  logic [3:0]        pos;
  logic [PHASES-1:0] mask;
  logic              later;
  logic              in_flush;
  logic [3:0]        flush_cnt;
  logic              flush_sel;
  logic              step_done;
  logic              final_tok;
  logic              advance;
  logic              out_valid;
  slot_t             slot;
  logic [NUMBER_BITS+62:0] num_wide;
  token_t            token_next;

  assign mask = {head.t3.valid, head.f2_cnt != 4'd0, head.t2.valid,
                 head.t1.valid, head.f1_cnt != 4'd0, head.first_mark};

  // first part at or after the current phase that has something to send
  always_comb begin
    cur   = PH_TOK3;
    later = 1'b0;
    for (int i = PHASES - 1; i >= 0; i--) begin
      if (mask[i] && 3'(i) >= phase) cur = phase_t'(3'(i));
    end
    for (int i = 0; i < PHASES; i++) begin
      if (mask[i] && 3'(i) > cur) later = 1'b1;
    end
  end

  assign in_flush  = (cur == PH_FLUSH1) || (cur == PH_FLUSH2);
  assign flush_cnt = (cur == PH_FLUSH1) ? head.f1_cnt : head.f2_cnt;
  assign flush_sel = (cur == PH_FLUSH1) ? head.f1_sel : head.f2_sel;
  assign step_done = !in_flush || (pos == flush_cnt - 4'd1);
  assign final_tok = step_done && !later;
  assign advance   = !head_empty && (!out_valid || pop);
  assign head_pop  = advance && final_tok;
  assign num_wide  = {63'b0, head.number};

  always_comb begin
    case (cur)
      PH_TOK1: slot = head.t1;
      PH_TOK2: slot = head.t2;
      default: slot = head.t3;
    endcase
    token_next = '0;
    case (cur)
      PH_LINE1: begin
        token_next.token_kind  = KIND_LINE;
        token_next.line_number = 32'd1;
      end
      PH_FLUSH1, PH_FLUSH2: begin
        token_next.token_kind = KIND_NAME_CHAR;
        token_next.char_value = kw_char(flush_sel, pos);
      end
      default: begin
        token_next.token_kind = slot.kind;
        token_next.char_value = slot.ch;
        if (slot.kind == KIND_NUMBER) token_next.number_value = num_wide[62:0];
        if (slot.kind == KIND_LINE) token_next.line_number = head.line;
      end
    endcase
    token_next.run_last   = final_tok;
    token_next.stream_end = final_tok && head.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_LINE1;
      pos       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        token     <= token_next;
        if (!step_done) begin
          pos <= pos + 4'd1;
        end else if (final_tok) begin
          phase <= PH_LINE1;
          pos   <= '0;
        end else begin
          phase <= phase_t'(3'(cur) + 3'd1);
          pos   <= '0;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

endmodule

FILE: src/source_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_top: byte-serial source tokenizer
// Classifier front, descriptor queue and token sequencer back.
// ----------------------------------------------------------------------------
// A source byte is taken whenever the four-entry descriptor queue has
// room; the classifier updates the scan state (string, name, number, line
// count) in that same cycle. Tokens leave the sequencer at one per cycle
// while the output register is empty or popped. Most bytes yield one
// token, a byte yields up to eleven when a held keyword prefix is replayed,
// and none when it only advances the scan state. Sustained rate is set
// by the token count through that single sequencer; the queue absorbs the
// bursts. No clearing pass is needed after reset.
module source_text_tokenizer_top import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  item_t  item,
  output logic   empty,
  input  logic   pop,
  output token_t token
);

  desc_t front_desc;
  logic  front_has;
  logic  take;
  desc_t head;
  logic  head_empty;
  logic  head_pop;

  assign take = push && !full;

  stt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .item       (item),
    .desc       (front_desc),
    .has_tokens (front_has)
  );

  // bytes with no tokens leave only their state change behind
  stt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take && front_has),
    .wr_data (front_desc),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (full),
    .empty   (head_empty)
  );

  stt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .token      (token)
  );

endmodule
